### rtl/core/rgh_pkg.sv
// Shared types and constants of the RGB/gray histogram block.
package rgh_pkg;

    localparam int BINS        = 256;
    localparam int LVL_W       = $clog2(BINS);
    localparam int NCHAN       = 4;
    localparam int CH_W        = 2;
    localparam int BAR_W       = 9;
    localparam int OUT_W       = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_ACC  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [CH_W-1:0] CH_LUMA  = 2'd0;
    localparam logic [CH_W-1:0] CH_RED   = 2'd1;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd2;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd3;

    // luma = (r*11 + g*16 + b*5) >> 5
    localparam int LUMA_KR    = 11;
    localparam int LUMA_KG    = 16;
    localparam int LUMA_KB    = 5;
    localparam int LUMA_SHIFT = 5;
    localparam int LUMA_W     = LVL_W + LUMA_SHIFT;

    typedef logic [LVL_W-1:0] t_lvl;

    typedef struct packed {
        logic                  op;
        logic [NCHAN-1:0]      mask;
        logic [CH_W-1:0]       channel;
        t_lvl [NCHAN-1:0]      lvl;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### rtl/core/rgb_gray_histogram.sv
// A read word passes the front-end register, the command queue, a store read and the divider
//   before its result strobe; a pixel shows no result. The back end works on one command at
//   a time: a store read, then a write back (pixel) or a 9-step bar-height divider (read word).
// The front end and a 2-deep command queue absorb short bursts; busy rises when they fill.
// Reset (synchronous, active low) starts a clearing pass over all 256 bins of all four stores;
//   busy stays high during it. Results are strobed for one cycle and cannot be stalled.
module rgb_gray_histogram
    import rgh_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  logic             i_mode,
    input  logic [LVL_W-1:0] i_red,
    input  logic [LVL_W-1:0] i_green,
    input  logic [LVL_W-1:0] i_blue,
    input  logic [CH_W-1:0]  i_channel,
    input  logic [LVL_W-1:0] i_bin,
    output logic             o_result_valid,
    output logic [OUT_W-1:0] o_bin_count,
    output logic [OUT_W-1:0] o_max_count,
    output logic [BAR_W-1:0] o_bar_height
);

    // front end -> queue
    logic                  q_push;
    t_cmd                  q_in;
    // queue -> back end
    t_cmd                  q_head;
    t_q_stat               q_stat;
    logic                  q_pop;
    // back end status and results
    logic                  clearing;
    logic [COUNT_BITS-1:0] bk_cnt;
    logic [COUNT_BITS-1:0] bk_mx;

    // Take words, hold the gray_source setting, work out luma and bin levels.
    rgh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_start     (start),
        .o_busy      (busy),
        .i_mode      (i_mode),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_channel   (i_channel),
        .i_bin       (i_bin),
        .i_q_stat    (q_stat),
        .i_clearing  (clearing),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    // Decouple the two halves so a slow read does not stall the front end at once.
    rgh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // Read-modify-write the bins, track maxima, divide for the bar height.
    rgh_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (q_stat),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_clearing   (clearing),
        .o_valid      (o_result_valid),
        .o_bin_count  (bk_cnt),
        .o_max_count  (bk_mx),
        .o_bar_height (o_bar_height)
    );

    // Counts wider than the ports drop their upper bits; narrower ones are zero-extended.
    assign o_bin_count = OUT_W'(bk_cnt);
    assign o_max_count = OUT_W'(bk_mx);

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command popped from an empty queue");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (busy && !o_result_valid))
        else $error("block not held off during the clearing pass");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> clearing)
        else $error("reset did not start the clearing pass");
`endif

endmodule

### rtl/core/rgh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rgh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rgh_front.sv
// Front end: takes words, computes luma and the bin levels, hands commands to the queue.
module rgh_front
    import rgh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_start,
    output logic             o_busy,
    input  logic             i_mode,
    input  logic [LVL_W-1:0] i_red,
    input  logic [LVL_W-1:0] i_green,
    input  logic [LVL_W-1:0] i_blue,
    input  logic [CH_W-1:0]  i_channel,
    input  logic [LVL_W-1:0] i_bin,
    input  t_q_stat          i_q_stat,
    input  logic             i_clearing,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic              r_gray_source;
    logic              r_vld;
    logic              n_vld;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic              accept;
    logic [LUMA_W-1:0] luma_sum;

    assign o_busy = i_clearing || (r_vld && i_q_stat.full);
    assign accept = i_start && !o_busy;
    assign o_push = r_vld && !i_q_stat.full;
    assign o_cmd  = r_cmd;

    assign luma_sum = LUMA_W'(i_red)   * LUMA_W'(LUMA_KR)
                    + LUMA_W'(i_green) * LUMA_W'(LUMA_KG)
                    + LUMA_W'(i_blue)  * LUMA_W'(LUMA_KB);

    always_comb begin
        n_cmd.op      = i_mode;
        n_cmd.channel = i_channel;
        if (i_mode == MODE_ACC) begin
            n_cmd.lvl[CH_LUMA]  = r_gray_source ? i_red : luma_sum[LUMA_W-1:LUMA_SHIFT];
            n_cmd.lvl[CH_RED]   = i_red;
            n_cmd.lvl[CH_GREEN] = i_green;
            n_cmd.lvl[CH_BLUE]  = i_blue;
            n_cmd.mask          = r_gray_source ? NCHAN'(1) : '1;
        end else begin
            // a read looks at the same bin in every store, the back end picks one
            n_cmd.lvl  = {NCHAN{i_bin}};
            n_cmd.mask = '0;
        end
    end

    always_comb begin
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_source <= 1'b0;
            r_vld         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gray_source <= i_cfg_wdata;
            end
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

### rtl/core/rgh_queue.sv
// Short command queue between the front end and the back end.
module rgh_queue
    import rgh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wptr;
    logic [QP_W-1:0] r_rptr;
    logic [QC_W-1:0] r_cnt;
    logic [QC_W-1:0] n_cnt;

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == QC_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QP_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QP_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/rgh_back.sv
// Back end: histogram stores, running maxima, bar-height divider and the clearing pass.
module rgh_back
    import rgh_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q_stat               i_q_stat,
    input  t_cmd                  i_head,
    output logic                  o_pop,
    output logic                  o_clearing,
    output logic                  o_valid,
    output logic [COUNT_BITS-1:0] o_bin_count,
    output logic [COUNT_BITS-1:0] o_max_count,
    output logic [BAR_W-1:0]      o_bar_height
);

    localparam int DIV_W  = COUNT_BITS + BAR_W;
    localparam int ITER_W = $clog2(BAR_W);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RD    = 2'd2;
    localparam logic [1:0] ST_DIV   = 2'd3;

    logic [1:0]            r_state,    n_state;
    logic [LVL_W-1:0]      r_clr_addr, n_clr_addr;
    t_cmd                  r_cmd,      n_cmd;
    logic [COUNT_BITS-1:0] r_max [NCHAN];
    logic [COUNT_BITS-1:0] n_max [NCHAN];
    logic [COUNT_BITS-1:0] r_rem,      n_rem;
    logic [DIV_W-1:0]      r_div,      n_div;
    logic [BAR_W-1:0]      r_quo,      n_quo;
    logic [ITER_W-1:0]     r_iter,     n_iter;
    logic [COUNT_BITS-1:0] r_cnt,      n_cnt;
    logic [COUNT_BITS-1:0] r_mx,       n_mx;
    logic                  r_out_vld,  n_out_vld;
    logic [BAR_W-1:0]      r_out_bar,  n_out_bar;

    logic [NCHAN-1:0]      ram_we;
    t_lvl [NCHAN-1:0]      ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata [NCHAN];
    logic                  ram_re;
    logic [COUNT_BITS-1:0] ram_rdata [NCHAN];
    logic [COUNT_BITS-1:0] inc       [NCHAN];

    logic [COUNT_BITS-1:0] sel_cnt;
    logic [COUNT_BITS-1:0] sel_mx;
    logic [COUNT_BITS-1:0] sel_hi;
    logic [COUNT_BITS-1:0] step;
    logic                  fits;
    logic [BAR_W-1:0]      quo_next;

    for (genvar g = 0; g < NCHAN; g++) begin : g_store
        rgh_ram #(
            .WIDTH (COUNT_BITS),
            .DEPTH (BINS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we[g]),
            .i_waddr (ram_waddr[g]),
            .i_wdata (ram_wdata[g]),
            .i_re    (ram_re),
            .i_raddr (i_head.lvl[g]),
            .o_rdata (ram_rdata[g])
        );
    end

    always_comb begin
        for (int k = 0; k < NCHAN; k++) begin
            // saturate at the top of the count range
            inc[k] = (&ram_rdata[k]) ? ram_rdata[k] : ram_rdata[k] + COUNT_BITS'(1);
        end
        sel_cnt  = ram_rdata[r_cmd.channel];
        sel_mx   = r_max[r_cmd.channel];
        sel_hi   = sel_mx >> LVL_W;
        step     = (sel_hi == '0) ? COUNT_BITS'(1) : sel_hi;
        fits     = (DIV_W'(r_rem) >= r_div);
        quo_next = {r_quo[BAR_W-2:0], fits};
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cmd      = r_cmd;
        n_max      = r_max;
        n_rem      = r_rem;
        n_div      = r_div;
        n_quo      = r_quo;
        n_iter     = r_iter;
        n_cnt      = r_cnt;
        n_mx       = r_mx;
        n_out_vld  = 1'b0;
        n_out_bar  = r_out_bar;
        o_pop      = 1'b0;
        ram_re     = 1'b0;
        ram_we     = '0;
        ram_waddr  = r_cmd.lvl;
        for (int k = 0; k < NCHAN; k++) begin
            ram_wdata[k] = inc[k];
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we    = '1;
                ram_waddr = {NCHAN{r_clr_addr}};
                for (int k = 0; k < NCHAN; k++) begin
                    ram_wdata[k] = '0;
                end
                n_clr_addr = r_clr_addr + LVL_W'(1);
                if (r_clr_addr == LVL_W'(BINS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    ram_re  = 1'b1;
                    n_cmd   = i_head;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                if (r_cmd.op == MODE_READ) begin
                    n_cnt   = sel_cnt;
                    n_mx    = sel_mx;
                    n_rem   = sel_cnt;
                    n_div   = DIV_W'(step) << (BAR_W - 1);
                    n_quo   = '0;
                    n_iter  = ITER_W'(BAR_W - 1);
                    n_state = ST_DIV;
                end else begin
                    for (int k = 0; k < NCHAN; k++) begin
                        if (r_cmd.mask[k]) begin
                            ram_we[k] = 1'b1;
                            if (r_max[k] < inc[k]) begin
                                n_max[k] = inc[k];
                            end
                        end
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (fits) begin
                    n_rem = r_rem - r_div[COUNT_BITS-1:0];
                end
                n_quo  = quo_next;
                n_div  = r_div >> 1;
                n_iter = r_iter - ITER_W'(1);
                if (r_iter == '0) begin
                    n_out_vld = 1'b1;
                    if (r_cnt == '0) begin
                        n_out_bar = '0;
                    end else if (quo_next == '0) begin
                        n_out_bar = BAR_W'(1);
                    end else begin
                        n_out_bar = quo_next;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
            for (int k = 0; k < NCHAN; k++) begin
                r_max[k] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_out_vld  <= n_out_vld;
            r_max      <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_quo     <= n_quo;
        r_iter    <= n_iter;
        r_cnt     <= n_cnt;
        r_mx      <= n_mx;
        r_out_bar <= n_out_bar;
    end

    assign o_clearing   = (r_state == ST_CLEAR);
    assign o_valid      = r_out_vld;
    assign o_bin_count  = r_cnt;
    assign o_max_count  = r_mx;
    assign o_bar_height = r_out_bar;

endmodule
